@@ rtl/vwma_pkg.sv @@
// shared types and constants of the volume weighted moving average
`default_nettype none

package vwma_pkg;

    localparam int PRICE_W = 24;
    localparam int VOL_W   = 24;
    localparam int PROD_W  = PRICE_W + VOL_W;
    localparam int WSUM_W  = 56;
    localparam int VSUM_W  = 32;
    localparam int WLEN_W  = 9;
    localparam int QUOT_W  = 24;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;
    localparam int USER_W  = 2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(20);
    localparam logic [QUOT_W-1:0] QUOT_MAX   = '1;

    typedef struct packed {
        logic accept;
        logic mul_old;
        logic sub_old;
        logic add_new;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic early;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/vwma_ctrl.sv @@
// controller state machine: sequences update, divide and result handoff
`default_nettype none

module vwma_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    input  vwma_pkg::sts_t   sts,
    output vwma_pkg::cmd_t   cmd
);
    import vwma_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULO = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MULO;
                end
            end
            ST_MULO: begin
                cmd.mul_old = 1'b1;
                state_next  = ST_SUB;
            end
            ST_SUB: begin
                cmd.sub_old = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_new = 1'b1;
                state_next  = ST_CHK;
            end
            ST_CHK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = sts.early ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vwma_datapath.sv @@
// datapath: sample rings, running sums, shared multiplier, restoring divider
`default_nettype none

module vwma_datapath #(
    parameter int MAX_WINDOW = 256
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  vwma_pkg::cmd_t                cmd,
    output vwma_pkg::sts_t                sts,
    input  wire                           cfg_wen,
    input  wire [vwma_pkg::WLEN_W-1:0]    cfg_wdata,
    input  wire [vwma_pkg::IN_W-1:0]      s_tdata,
    output logic [vwma_pkg::OUT_W-1:0]    m_tdata,
    output logic [vwma_pkg::USER_W-1:0]   m_tuser
);
    import vwma_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = ((AW > WLEN_W) ? AW : WLEN_W) + 1;
    localparam int WLEN_TOP = (1 << WLEN_W) - 1;
    localparam logic [WLEN_W-1:0] WMAX =
        WLEN_W'((MAX_WINDOW > WLEN_TOP) ? WLEN_TOP : MAX_WINDOW);
    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);

    logic [PRICE_W-1:0] price_mem [MAX_WINDOW];
    logic [VOL_W-1:0]   vol_mem   [MAX_WINDOW];

    logic [WLEN_W-1:0]  wlen_reg;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [WLEN_W-1:0]  fill_reg, fill_next;
    logic [WSUM_W-1:0]  ws_reg;
    logic [VSUM_W-1:0]  vs_reg;
    logic [PRICE_W-1:0] in_p_reg, rd_p_reg;
    logic [VOL_W-1:0]   in_v_reg, rd_v_reg;
    logic               sub_reg, ready_reg, zero_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VSUM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0]  dlo_reg, quot_reg;
    logic [QUOT_W-1:0]  avg_reg;
    logic               out_ready_reg, out_zero_reg;

    logic [WLEN_W-1:0]  w_eff;
    logic               full_now;
    logic [SW-1:0]      slot_ext, w_ext, old_ext;
    logic [AW-1:0]      old_idx;
    logic               vs_zero, sat;
    logic [VSUM_W:0]    trial, diff;
    logic               ge;

    always_comb begin
        if (wlen_reg == '0) begin
            w_eff = WLEN_W'(1);
        end else if (wlen_reg > WMAX) begin
            w_eff = WMAX;
        end else begin
            w_eff = wlen_reg;
        end
        full_now  = (fill_reg >= w_eff);
        fill_next = full_now ? fill_reg : fill_reg + WLEN_W'(1);
        slot_ext  = SW'(slot_reg);
        w_ext     = SW'(w_eff);
        old_ext   = (slot_ext >= w_ext) ? slot_ext - w_ext
                                        : slot_ext + SW'(MAX_WINDOW) - w_ext;
        old_idx   = old_ext[AW-1:0];
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + AW'(1);
    end

    // saturation test and divider step
    assign vs_zero   = (vs_reg == '0);
    assign sat       = (ws_reg >= {vs_reg, {(WSUM_W-VSUM_W){1'b0}}});
    assign sts.early = vs_zero || sat;
    assign trial     = {rem_reg, dlo_reg[QUOT_W-1]};
    assign ge        = (trial >= {1'b0, vs_reg});
    assign diff      = trial - {1'b0, vs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
            slot_reg <= '0;
            fill_reg <= '0;
            ws_reg   <= '0;
            vs_reg   <= '0;
        end else if (cfg_wen) begin
            wlen_reg <= cfg_wdata;
            slot_reg <= '0;
            fill_reg <= '0;
            ws_reg   <= '0;
            vs_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
            if (cmd.mul_old && sub_reg) begin
                vs_reg <= vs_reg - VSUM_W'(rd_v_reg);
            end
            if (cmd.sub_old) begin
                ws_reg <= ws_reg - WSUM_W'(prod_reg);
                vs_reg <= vs_reg + VSUM_W'(in_v_reg);
            end
            if (cmd.add_new) begin
                ws_reg <= ws_reg + WSUM_W'(prod_reg);
            end
        end
    end

    // ring memories, read of the oldest pair before the new pair lands
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_p_reg           <= price_mem[old_idx];
            rd_v_reg           <= vol_mem[old_idx];
            price_mem[slot_reg] <= s_tdata[PRICE_W-1:0];
            vol_mem[slot_reg]   <= s_tdata[PRICE_W +: VOL_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_p_reg  <= s_tdata[PRICE_W-1:0];
            in_v_reg  <= s_tdata[PRICE_W +: VOL_W];
            sub_reg   <= full_now;
            ready_reg <= (fill_next >= w_eff);
        end
        if (cmd.mul_old) begin
            prod_reg <= sub_reg ? PROD_W'(rd_p_reg) * PROD_W'(rd_v_reg) : '0;
        end
        if (cmd.sub_old) begin
            prod_reg <= PROD_W'(in_p_reg) * PROD_W'(in_v_reg);
        end
        if (cmd.div_init) begin
            rem_reg  <= ws_reg[WSUM_W-1 -: VSUM_W];
            dlo_reg  <= ws_reg[QUOT_W-1:0];
            zero_reg <= vs_zero;
            quot_reg <= (!vs_zero && sat) ? QUOT_MAX : '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? diff[VSUM_W-1:0] : trial[VSUM_W-1:0];
            dlo_reg  <= {dlo_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
        if (cmd.load_out) begin
            avg_reg       <= quot_reg;
            out_ready_reg <= ready_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    assign m_tdata = avg_reg;
    assign m_tuser = {out_zero_reg, out_ready_reg};

endmodule

`default_nettype wire

@@ rtl/volume_weighted_moving_average.sv @@
// a request runs through accept, the update of the sums, a check and the 24-step restoring divider
// into the output register; the divider is skipped when the volume sum is zero or the average saturates
// no new request is taken until the result is loaded; the update uses one shared 24x24 multiplier
// reset: synchronous active low; clears window, sums and handshake state
// and sets window_len to 20; ring contents are not cleared and need no pass
`default_nettype none

module volume_weighted_moving_average #(
    parameter int MAX_WINDOW = 256
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_wen,
    input  wire [vwma_pkg::WLEN_W-1:0]    cfg_wdata,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [vwma_pkg::IN_W-1:0]      s_tdata,   // price, volume
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [vwma_pkg::OUT_W-1:0]    m_tdata,   // average
    output logic [vwma_pkg::USER_W-1:0]   m_tuser    // ready_res, zero_volume
);
    import vwma_pkg::*;

    cmd_t cmd;
    sts_t sts;

    vwma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vwma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/vwma_checker.sv @@
// port-level checks of the moving average block and their binding
`default_nettype none

module vwma_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [vwma_pkg::OUT_W-1:0]    m_tdata,
    input wire [vwma_pkg::USER_W-1:0]   m_tuser
);
    import vwma_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in work");

    a_zero_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("zero volume with nonzero average");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("handshake not idle after reset");

endmodule

bind volume_weighted_moving_average vwma_checker u_vwma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/volume_weighted_moving_average_tb.sv @@
// testbench of the volume weighted moving average: random and directed ticks, in-bench model
`timescale 1ns / 100ps

module volume_weighted_moving_average_tb;
    import vwma_pkg::*;

    localparam int RING_DEPTH   = 256;
    localparam int SLOT_W       = $clog2(RING_DEPTH);
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [VOL_W-1:0]   volume;
        logic [PRICE_W-1:0] price;
    } tick_t;

    typedef struct packed {
        logic              zero_volume;
        logic              ready_res;
        logic [QUOT_W-1:0] average;
    } vwap_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [WLEN_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire [OUT_W-1:0]   m_tdata;
    wire [USER_W-1:0]  m_tuser;

    volume_weighted_moving_average #(
        .MAX_WINDOW(RING_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    tick_t tick_q[$];
    vwap_t vwap_q[$];

    int errors = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int full_seen = 0;
    int zero_seen = 0;
    int windows_set = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_count = 0;
    int idle_cycles = 0;
    bit hold_go = 1'b0;

    logic [PRICE_W-1:0] price_hist [RING_DEPTH];
    logic [VOL_W-1:0]   vol_hist [RING_DEPTH];
    logic [SLOT_W-1:0]  next_slot;
    logic [WLEN_W-1:0]  filled;
    logic [WSUM_W-1:0]  pv_sum;
    logic [VSUM_W-1:0]  vol_sum;
    logic [WLEN_W-1:0]  win_len;

    function automatic void restart_window(input logic [WLEN_W-1:0] len);
        win_len   = len;
        next_slot = '0;
        filled    = '0;
        pv_sum    = '0;
        vol_sum   = '0;
    endfunction

    function automatic vwap_t vwap_update(input tick_t t);
        int                span;
        int                oldest;
        logic [WSUM_W-1:0] quot;
        vwap_t             r;
        span = (win_len == 0) ? 1 : (int'(win_len) > RING_DEPTH) ? RING_DEPTH : int'(win_len);
        if (int'(filled) >= span) begin
            oldest  = (int'(next_slot) + RING_DEPTH - span) % RING_DEPTH;
            pv_sum  = pv_sum - WSUM_W'(price_hist[oldest]) * WSUM_W'(vol_hist[oldest]);
            vol_sum = vol_sum - VSUM_W'(vol_hist[oldest]);
        end else begin
            filled = filled + 1'b1;
        end
        pv_sum  = pv_sum + WSUM_W'(t.price) * WSUM_W'(t.volume);
        vol_sum = vol_sum + VSUM_W'(t.volume);
        price_hist[next_slot] = t.price;
        vol_hist[next_slot]   = t.volume;
        next_slot = next_slot + 1'b1;
        r.zero_volume = (vol_sum == '0);
        r.ready_res   = (int'(filled) >= span);
        if (r.zero_volume) begin
            r.average = '0;
        end else begin
            quot      = pv_sum / WSUM_W'(vol_sum);
            r.average = (quot > WSUM_W'(QUOT_MAX)) ? QUOT_MAX : quot[QUOT_W-1:0];
        end
        return r;
    endfunction

    function automatic tick_t make_tick(input logic [PRICE_W-1:0] price,
                                        input logic [VOL_W-1:0] volume);
        tick_t t;
        t.price  = price;
        t.volume = volume;
        return t;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        case ($urandom_range(0, 9))
            0, 1: t.volume = '0;
            2: t.volume = '1;
            3: t.volume = VOL_W'($urandom_range(1, 15));
            default: t.volume = VOL_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: t.price = '0;
            1: t.price = '1;
            default: t.price = PRICE_W'($urandom);
        endcase
        return t;
    endfunction

    task automatic wait_drain();
        @(negedge aclk);
        while (tick_q.size() != 0 || s_tvalid || vwap_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_window(input logic [WLEN_W-1:0] len);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= len;
        restart_window(len);
        windows_set++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_ticks(input int count, input int s_pct, input int m_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = m_pct;
        for (int i = 0; i < count; i++)
            tick_q.insert(tick_q.size(), random_tick());
        wait_drain();
    endtask

    // driver: presents queued requests, random gaps only while no request is held
    always @(posedge aclk) begin : driver
        logic            valid_nx;
        logic [IN_W-1:0] data_nx;
        valid_nx = s_tvalid;
        data_nx  = s_tdata;
        if (!aresetn) begin
            valid_nx = 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                vwap_q.insert(vwap_q.size(), vwap_update(tick_t'(s_tdata)));
                ticks_sent++;
                valid_nx = 1'b0;
            end
            if (!valid_nx) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (tick_q.size() > 0) begin
                    if ($urandom_range(0, 99) < send_idle_pct) begin
                        send_gap = $urandom_range(0, 18);
                    end else begin
                        data_nx  = tick_q.pop_front();
                        valid_nx = 1'b1;
                    end
                end
            end
        end
        s_tvalid <= valid_nx;
        s_tdata  <= data_nx;
    end

    // monitor: checks each result against the oldest expected average
    always @(posedge aclk) begin : monitor
        vwap_t got;
        vwap_t want;
        logic  ready_nx;
        ready_nx = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                results_seen++;
                if (got.ready_res)
                    full_seen++;
                if (got.zero_volume)
                    zero_seen++;
                if (vwap_q.size() == 0) begin
                    $error("result with no request pending: average %0h", got.average);
                    errors++;
                end else begin
                    want = vwap_q.pop_front();
                    if (got.average !== want.average) begin
                        $error("average: expected %0h, got %0h", want.average, got.average);
                        errors++;
                    end
                    if (got.ready_res !== want.ready_res) begin
                        $error("ready_res: expected %0b, got %0b", want.ready_res, got.ready_res);
                        errors++;
                    end
                    if (got.zero_volume !== want.zero_volume) begin
                        $error("zero_volume: expected %0b, got %0b",
                               want.zero_volume, got.zero_volume);
                        errors++;
                    end
                end
            end
            if (hold_go && hold_count < HOLD_CYCLES) begin
                hold_count++;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 18);
            end else begin
                ready_nx = 1'b1;
            end
        end
        m_tready <= ready_nx;
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) begin
            price_hist[i] = '0;
            vol_hist[i]   = '0;
        end
        restart_window(WLEN_RESET);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes at the reset window, then a whole window of zero volume
        send_idle_pct = 20;
        recv_idle_pct = 20;
        tick_q.insert(tick_q.size(), make_tick('1, '0));
        tick_q.insert(tick_q.size(), make_tick('1, '1));
        tick_q.insert(tick_q.size(), make_tick('0, '1));
        tick_q.insert(tick_q.size(), make_tick(PRICE_W'(1), VOL_W'(1)));
        for (int i = 0; i < 20; i++)
            tick_q.insert(tick_q.size(), make_tick(PRICE_W'($urandom), '0));
        tick_q.insert(tick_q.size(), make_tick(24'hAAAAAA, 24'h555555));
        run_ticks(40, 20, 20);

        set_window(WLEN_W'(1));
        run_ticks(30, 0, 0);
        set_window(WLEN_W'(0));
        run_ticks(20, 40, 10);
        set_window(WLEN_W'(5));
        run_ticks(40, 10, 40);
        set_window(WLEN_W'(511));
        run_ticks(20, 20, 20);

        // full ring with a long receiver stall so the input backs up
        set_window(WLEN_W'(256));
        hold_go = 1'b1;
        run_ticks(270, 0, 15);

        set_window(WLEN_W'(2));
        run_ticks(30, 30, 30);
        set_window(WLEN_W'($urandom_range(2, 40)));
        run_ticks(45, 15, 15);
        set_window(WLEN_W'($urandom_range(0, 511)));
        run_ticks(15, 50, 50);

        // closing stretch without idling
        set_window(WLEN_W'(17));
        run_ticks(40, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d ticks and %0d averages over %0d window lengths incl. 0, 1, 256, 511",
                 ticks_sent, results_seen, windows_set + 1);
        $display("%0d averages over a full window, %0d with zero window volume",
                 full_seen, zero_seen);
        if (errors == 0 && vwap_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
